>>> hdl/fde_pkg.sv
package fde_pkg;

  localparam int unsigned RunDepth = 8;
  localparam int unsigned LenWidth = 4;

  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharCr      = 8'h0d;
  localparam logic [7:0] CharLf      = 8'h0a;
  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] DirChar     = 8'h63;  // 'c'
  localparam logic [7:0] DirDec      = 8'h64;  // 'd'
  localparam logic [7:0] DirBin      = 8'h62;  // 'b'
  localparam logic [7:0] DirNewline  = 8'h6e;  // 'n'

  // One decoded run: the bytes in emission order and how many are valid.
  typedef struct packed {
    logic [RunDepth-1:0][7:0] bytes;
    logic [LenWidth-1:0]      len;
  } fde_run_t;

endpackage

>>> hdl/fde_decode.sv
module fde_decode (
  input  logic [7:0]       fmt_char_i,
  input  logic [7:0]       arg_byte_i,
  input  logic             pending_i,
  output fde_pkg::fde_run_t run_o,
  output logic             pending_o
);
  import fde_pkg::*;

  logic [1:0]  hundreds;
  logic [6:0]  rem100;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  units;
  logic [7:0]  hund_sub;
  logic [6:0]  tens_x10;

  // Decimal split: compares for hundreds, a reciprocal multiply for tens
  // (exact for remainders below 100).
  always_comb begin
    if (arg_byte_i >= 8'd200) begin
      hundreds = 2'd2;
      hund_sub = 8'd200;
    end else if (arg_byte_i >= 8'd100) begin
      hundreds = 2'd1;
      hund_sub = 8'd100;
    end else begin
      hundreds = 2'd0;
      hund_sub = 8'd0;
    end
    rem100    = 7'(arg_byte_i - hund_sub);
    tens_prod = 15'(rem100) * 15'd205;
    tens      = tens_prod[14:11];
    tens_x10  = 7'({3'b000, tens} * 7'd10);
    units     = 4'(rem100 - tens_x10);
  end

  always_comb begin
    run_o.bytes = '0;
    run_o.len   = '0;
    pending_o   = pending_i;
    if (fmt_char_i == CharNul) begin
      pending_o = 1'b0;
      if (pending_i) begin
        run_o.bytes[0] = CharPercent;
        run_o.len      = 4'd1;
      end
    end else if (!pending_i) begin
      if (fmt_char_i == CharPercent) begin
        pending_o = 1'b1;
      end else begin
        run_o.bytes[0] = fmt_char_i;
        run_o.len      = 4'd1;
      end
    end else begin
      pending_o = 1'b0;
      unique case (fmt_char_i)
        DirChar: begin
          run_o.bytes[0] = arg_byte_i;
          run_o.len      = 4'd1;
        end
        DirDec: begin
          if (hundreds != 2'd0) begin
            run_o.bytes[0] = CharZero + {6'd0, hundreds};
            run_o.bytes[1] = CharZero + {4'd0, tens};
            run_o.bytes[2] = CharZero + {4'd0, units};
            run_o.len      = 4'd3;
          end else if (tens != 4'd0) begin
            run_o.bytes[0] = CharZero + {4'd0, tens};
            run_o.bytes[1] = CharZero + {4'd0, units};
            run_o.len      = 4'd2;
          end else begin
            run_o.bytes[0] = CharZero + {4'd0, units};
            run_o.len      = 4'd1;
          end
        end
        DirBin: begin
          for (int i = 0; i < RunDepth; i++) begin
            run_o.bytes[i] = CharZero + {7'd0, arg_byte_i[RunDepth-1-i]};
          end
          run_o.len = 4'(RunDepth);
        end
        DirNewline: begin
          run_o.bytes[0] = CharCr;
          run_o.bytes[1] = CharLf;
          run_o.len      = 4'd2;
        end
        default: begin
          // Unknown directive: the held percent goes out, then the character
          // as an ordinary one, which may itself be a new percent.
          run_o.bytes[0] = CharPercent;
          if (fmt_char_i == CharPercent) begin
            pending_o = 1'b1;
            run_o.len = 4'd1;
          end else begin
            run_o.bytes[1] = fmt_char_i;
            run_o.len      = 4'd2;
          end
        end
      endcase
    end
  end

endmodule

>>> hdl/format_directive_expander.sv
// Format directive expander. Each input beat carries one format character and
// one argument byte; the block answers with zero to eight output beats, the
// last of which has last_of_run_o set. A '%' is held until the next character,
// which picks the directive: 'c' sends the argument, 'd' sends it in decimal
// without leading zeros, 'b' sends eight binary digits MSB first, 'n' sends
// CR LF, and anything else sends the held '%' followed by the character; a
// second '%' is held anew. A zero character ends the string and flushes a
// held '%'. The block decodes a character in the cycle it is accepted into
// a run register, and the run register feeds an output register one byte per
// cycle while that register is free or being emptied. A new input beat is
// taken once the run register is empty or in the cycle that it hands its
// last byte to the output register, so the input rate is set by the output,
// and a beat waits while the run register still has bytes to hand on.
module format_directive_expander (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] fmt_char_i,
  input  logic [7:0] arg_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import fde_pkg::*;

  // Directive state: a percent is waiting for its selector character.
  logic pending_q, pending_d;

  // Run register: the decoded bytes of one input beat and the read position.
  fde_run_t                    run_q, run_d;
  logic                        run_valid_q, run_valid_d;
  logic [$clog2(RunDepth)-1:0] pos_q, pos_d;

  // Output register in front of the downstream port.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  fde_run_t dec_run;
  logic     dec_pending;
  logic     accept;
  logic     move;
  logic     run_last;

  fde_decode u_decode (
    .fmt_char_i (fmt_char_i),
    .arg_byte_i (arg_byte_i),
    .pending_i  (pending_q),
    .run_o      (dec_run),
    .pending_o  (dec_pending)
  );

  // A byte moves from the run register when the output register is free or is
  // being emptied in this cycle.
  assign move     = run_valid_q && (!out_valid_q || out_ready_i);
  assign run_last = ({1'b0, pos_q} == (run_q.len - 4'd1));

  // A new beat may enter once the run register is empty or hands over its
  // final byte in this cycle.
  assign in_ready_o = !run_valid_q || (move && run_last);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pending_d   = pending_q;
    run_d       = run_q;
    run_valid_d = run_valid_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d = 1'b1;
      out_byte_d  = run_q.bytes[pos_q];
      out_last_d  = run_last;
      pos_d       = pos_q + 1'b1;
      if (run_last) begin
        run_valid_d = 1'b0;
      end
    end

    // A beat that causes no output only updates the directive state.
    if (accept) begin
      pending_d = dec_pending;
      if (dec_run.len != '0) begin
        run_d       = dec_run;
        run_valid_d = 1'b1;
        pos_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      run_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      run_valid_q <= run_valid_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

>>> tb/format_directive_expander_tb.sv
`timescale 1ns / 100ps

module format_directive_expander_tb;
  import fde_pkg::*;

  // Clock period in ns and the number of clocks that the reset is held.
  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned ResetCycles = 5;
  // The slowest correct run is roughly 100 characters times eight output beats,
  // each beat waiting out the longest random stall, plus gaps and the long hold-off.
  // That stays well below this limit, so the limit leaves ample room.
  localparam int unsigned CycleLimit = 60000;
  // The receiver holds off for this many cycles once, so that the block fills up.
  localparam int unsigned LongHoldCycles = 80;
  // Cycles allowed after the last expected beat, in case a spurious beat follows.
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomItems = 75;

  // One expected output beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // The scoreboard keeps its own copy of the percent flag. Each accepted
  // character is expanded into the output beats it should cause, and those
  // beats are queued in order. Each output beat from the block is then
  // checked against the oldest entry in the queue.
  class expander_scoreboard;
    bit          pct_held;
    out_beat_t   out_bytes_q[$];
    int unsigned n_fail;
    int unsigned chars_noted;
    int unsigned directives_seen;
    int unsigned beats_checked;

    function void note_char(logic [7:0] ch, logic [7:0] arg);
      logic [7:0] run_q[$];
      logic [7:0] hundreds;
      logic [7:0] tens;
      logic [7:0] units;
      int         i;
      hundreds = arg / 8'd100;
      tens     = (arg % 8'd100) / 8'd10;
      units    = arg % 8'd10;
      chars_noted++;
      if (ch == CharNul) begin
        // The end of the string flushes a held percent.
        if (pct_held) run_q.push_back(CharPercent);
        pct_held = 1'b0;
      end else if (!pct_held) begin
        if (ch == CharPercent) pct_held = 1'b1;
        else run_q.push_back(ch);
      end else begin
        pct_held = 1'b0;
        case (ch)
          DirChar: begin
            directives_seen++;
            run_q.push_back(arg);
          end
          DirDec: begin
            directives_seen++;
            if (hundreds != 0) run_q.push_back(hundreds + CharZero);
            if (hundreds != 0 || tens != 0) run_q.push_back(tens + CharZero);
            run_q.push_back(units + CharZero);
          end
          DirBin: begin
            directives_seen++;
            for (i = 7; i >= 0; i--) run_q.push_back({7'b0, arg[i]} + CharZero);
          end
          DirNewline: begin
            directives_seen++;
            run_q.push_back(CharCr);
            run_q.push_back(CharLf);
          end
          default: begin
            // An unknown character emits the held percent and is then handled
            // as plain text. A second percent becomes the new held one.
            run_q.push_back(CharPercent);
            if (ch == CharPercent) pct_held = 1'b1;
            else run_q.push_back(ch);
          end
        endcase
      end
      foreach (run_q[k]) out_bytes_q.push_back('{data: run_q[k], last: (k == run_q.size() - 1)});
    endfunction

    function void check_beat(logic [7:0] data, logic last);
      out_beat_t want;
      if (out_bytes_q.size() == 0) begin
        $error("out_byte: expected no beat, got %h", data);
        n_fail++;
        return;
      end
      want = out_bytes_q.pop_front();
      beats_checked++;
      if (data !== want.data) begin
        $error("out_byte: expected %h, got %h", want.data, data);
        n_fail++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, got %b", want.last, last);
        n_fail++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] fmt_char_i;
  logic [7:0] arg_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  expander_scoreboard sb;

  // When idle_on is set, both sides insert short random bursts of idle cycles.
  // The final part of the run clears it, so that the block runs at full rate.
  bit          idle_on;
  // The stimulus process sets this flag to ask the receiver for one long
  // hold-off. The receiver clears it when the hold-off starts.
  bit          long_hold_req;
  int unsigned cycle_count;
  int unsigned items_sent;

  format_directive_expander dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .fmt_char_i   (fmt_char_i),
    .arg_byte_i   (arg_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog. If the block hangs or drops a beat, the run ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, sb.out_bytes_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output beats are taken at the rising edge at which valid and ready are
  // both high. Values are read before the edge updates anything, because
  // every input changes only at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_beat(out_byte_o, last_of_run_o);
  end

  // Receiver. Ready changes only at the falling edge. It drops at random, or
  // for one long stretch when the stimulus asks for it.
  initial begin : receiver
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LongHoldCycles;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left  = $urandom_range(1, 4) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Sends one character beat. The task is called at a falling edge. It may
  // first idle for a short burst. It then holds valid and the payload until
  // the beat is accepted, and it returns at the next falling edge. Valid is
  // left high there, so a call made right away that does not idle keeps the channel busy.
  task automatic send_char(input logic [7:0] ch, input logic [7:0] arg);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      fmt_char_i <= 8'($urandom);
      arg_byte_i <= 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    fmt_char_i <= ch;
    arg_byte_i <= arg;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_char(ch, arg);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Sends a random group of characters. Most groups are complete directives
  // with a random argument. The rest are plain characters, percent signs
  // followed by anything, and end-of-string markers.
  task automatic send_random_group();
    int unsigned pick;
    logic [7:0]  dir_q[$];
    dir_q = '{DirChar, DirDec, DirBin, DirNewline};
    pick  = $urandom_range(0, 99);
    if (pick < 60) begin
      send_char(CharPercent, 8'($urandom));
      send_char(dir_q[$urandom_range(0, 3)], 8'($urandom));
    end else if (pick < 75) begin
      send_char(8'($urandom_range(1, 255)), 8'($urandom));
    end else if (pick < 87) begin
      send_char(CharPercent, 8'($urandom));
      send_char(8'($urandom), 8'($urandom));
    end else if (pick < 95) begin
      send_char(CharNul, 8'($urandom));
    end else begin
      send_char(8'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_for_drain();
    while (sb.out_bytes_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned random_start;
    sb            = new();
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    cycle_count   = 0;
    items_sent    = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    fmt_char_i    = '0;
    arg_byte_i    = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The directed part. It starts with plain characters at both ends of the
    // range, then tries each directive with boundary arguments.
    send_char(8'h41, 8'($urandom));
    send_char(8'hff, 8'($urandom));
    send_char(8'h01, 8'($urandom));
    send_char(CharPercent, 8'h00);
    send_char(DirChar, 8'hff);
    send_char(CharPercent, 8'hff);
    send_char(DirDec, 8'h00);
    send_char(CharPercent, 8'h00);
    send_char(DirDec, 8'd255);
    send_char(CharPercent, 8'h00);
    send_char(DirDec, 8'd100);
    send_char(CharPercent, 8'h00);
    send_char(DirDec, 8'd42);
    send_char(CharPercent, 8'h00);
    send_char(DirBin, 8'ha5);
    send_char(CharPercent, 8'h5a);
    send_char(DirNewline, 8'h5a);
    // Two percent signs in a row. The first is emitted and the second is
    // held. An unknown character then flushes the held percent and is
    // emitted after it.
    send_char(CharPercent, 8'($urandom));
    send_char(CharPercent, 8'($urandom));
    send_char(8'h78, 8'($urandom));
    // Directive letters without a held percent are ordinary characters.
    send_char(DirChar, 8'($urandom));
    send_char(DirDec, 8'($urandom));
    send_char(DirBin, 8'($urandom));
    send_char(DirNewline, 8'($urandom));
    // The end of the string with a percent held, and then with nothing held.
    send_char(CharPercent, 8'($urandom));
    send_char(CharNul, 8'($urandom));
    send_char(CharNul, 8'($urandom));

    // The random part, first with idling on both sides.
    random_start = items_sent;
    while (items_sent - random_start < 20) send_random_group();

    // The receiver holds off for a long stretch while characters keep
    // coming, so that the block fills up and stalls its input.
    long_hold_req = 1'b1;
    repeat (10) begin
      send_char(CharPercent, 8'($urandom));
      send_char(DirBin, 8'($urandom));
    end

    // The sender pauses until every expected beat has come out.
    in_valid_i <= 1'b0;
    wait_for_drain();

    while (items_sent - random_start < 55) send_random_group();

    // The last stretch runs with no idling on either side.
    idle_on = 1'b0;
    while (items_sent - random_start < RandomItems) send_random_group();

    in_valid_i <= 1'b0;
    wait_for_drain();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d format characters, %0d of them completing a directive,",
             sb.chars_noted, sb.directives_seen);
    $display("and checked %0d output beats across idle bursts and one long output stall.",
             sb.beats_checked);
    if (sb.n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.n_fail);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> format_directive_expander.f
hdl/fde_pkg.sv
hdl/fde_decode.sv
hdl/format_directive_expander.sv
tb/format_directive_expander_tb.sv
